[src/teq_pkg.sv]
`timescale 1ns / 1ps

package teq_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int TIME_BITS   = 48;
    localparam int SLOT_BITS   = $clog2(QUEUE_DEPTH);
    localparam int COUNT_BITS  = $clog2(QUEUE_DEPTH + 1);

    localparam int OP_BITS     = 2;
    localparam int DELAY_BITS  = 32;
    localparam int PERIOD_BITS = 32;
    localparam int TAG_BITS    = 16;
    localparam int HANDLE_BITS = 4;
    localparam int STATUS_BITS = 2;
    localparam int IDLE_BITS   = 16;

    localparam logic [IDLE_BITS-1:0] IDLE_WAIT_RESET = 16'd500;

    // input word layout
    localparam int S_NOW_LSB    = 0;
    localparam int S_DELAY_LSB  = S_NOW_LSB + TIME_BITS;
    localparam int S_PERIOD_LSB = S_DELAY_LSB + DELAY_BITS;
    localparam int S_TAG_LSB    = S_PERIOD_LSB + PERIOD_BITS;
    localparam int S_HANDLE_LSB = S_TAG_LSB + TAG_BITS;
    localparam int S_FIELD_BITS = S_HANDLE_LSB + HANDLE_BITS;
    localparam int S_TDATA_BITS = ((S_FIELD_BITS + 7) / 8) * 8;

    // result word layout
    localparam int M_HANDLE_LSB = 0;
    localparam int M_FIRED_LSB  = M_HANDLE_LSB + HANDLE_BITS;
    localparam int M_TAG_LSB    = M_FIRED_LSB + 1;
    localparam int M_WAIT_LSB   = M_TAG_LSB + TAG_BITS;
    localparam int M_FIELD_BITS = M_WAIT_LSB + TIME_BITS;
    localparam int M_TDATA_BITS = ((M_FIELD_BITS + 7) / 8) * 8;

    typedef logic [TIME_BITS-1:0]  time_t;
    typedef logic [SLOT_BITS-1:0]  slot_t;
    typedef logic [COUNT_BITS-1:0] count_t;

    typedef enum logic [OP_BITS-1:0] {
        OP_INSERT = 2'd0,
        OP_CANCEL = 2'd1,
        OP_RUN    = 2'd2,
        OP_QUERY  = 2'd3
    } op_t;

    typedef enum logic [STATUS_BITS-1:0] {
        ST_OK         = 2'd0,
        ST_FULL       = 2'd1,
        ST_NOT_QUEUED = 2'd2,
        ST_NOT_DUE    = 2'd3
    } status_t;

    typedef struct packed {
        logic capture;
        logic res_full;
        logic ins_setup;
        logic cancel_ok;
        logic cancel_miss;
        logic not_due;
        logic fire;
        logic query;
        logic walk_step;
        logic walk_link;
        logic load_out;
    } cmd_t;

    typedef struct packed {
        op_t  op;
        logic full;
        logic cancel_hit;
        logic head_due;
        logic period_nz;
        logic walk_more;
        logic out_busy;
    } stat_t;

    function automatic time_t sat_add(time_t a, logic [DELAY_BITS-1:0] b);
        logic [TIME_BITS:0] s;
        s = {1'b0, a} + (TIME_BITS + 1)'(b);
        return s[TIME_BITS] ? '1 : s[TIME_BITS-1:0];
    endfunction

endpackage

[src/timed_event_queue.sv]
`timescale 1ns / 1ps

// Channel  Dir  Handshake                      Payload
// s_axis   in   s_axis_tvalid / s_axis_tready  tuser operation, tdata event fields
// m_axis   out  m_axis_tvalid / m_axis_tready  tuser status, tdata result fields
// cfg      in   cfg_wr_en                      cfg_wr_data idle wait (ms)
//
// Cancel, query, insert on a full queue and a run that is not due or has no reload
// pass through accept, dispatch and result load.
// Accepted insert and periodic run add a sorted walk before result load, one walk step
// per entry passed (at most QUEUE_DEPTH - 1); the walk is bound by the single deadline read port.
// A new word is accepted while the previous result still waits on m_axis.
// Reset clears the slot valid bits and the queue count.
// A stalled result holds the next one in the finish state until m_axis drains.

module timed_event_queue (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // now_ms, delay_ms, period_ms, event_tag, cancel_handle, zero pad
    input  logic [teq_pkg::S_TDATA_BITS-1:0]  s_axis_tdata,
    // operation
    input  logic [teq_pkg::OP_BITS-1:0]       s_axis_tuser,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // new_handle, fired, fired_tag, wait_ms, zero pad
    output logic [teq_pkg::M_TDATA_BITS-1:0]  m_axis_tdata,
    // status
    output logic [teq_pkg::STATUS_BITS-1:0]   m_axis_tuser,
    input  logic                              cfg_wr_en,
    input  logic [teq_pkg::IDLE_BITS-1:0]     cfg_wr_data
);

    teq_pkg::cmd_t  cmd;
    teq_pkg::stat_t stat;

    teq_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_axis_tvalid),
        .s_ready (s_axis_tready),
        .stat    (stat),
        .cmd     (cmd)
    );

    teq_dp u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tdata     (s_axis_tdata),
        .s_tuser     (s_axis_tuser),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .cmd         (cmd),
        .stat        (stat),
        .m_tvalid    (m_axis_tvalid),
        .m_tready    (m_axis_tready),
        .m_tdata     (m_axis_tdata),
        .m_tuser     (m_axis_tuser)
    );

endmodule

[src/teq_ctrl.sv]
`timescale 1ns / 1ps

module teq_ctrl (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    input  teq_pkg::stat_t stat,
    output teq_pkg::cmd_t  cmd
);

    typedef enum logic [3:0] {
        FSM_IDLE     = 4'b0001,
        FSM_DISPATCH = 4'b0010,
        FSM_WALK     = 4'b0100,
        FSM_FINISH   = 4'b1000
    } fsm_t;

    fsm_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= FSM_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        case (state_reg)
            FSM_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.capture = 1'b1;
                    state_next  = FSM_DISPATCH;
                end
            end
            FSM_DISPATCH: begin
                state_next = FSM_FINISH;
                case (stat.op)
                    teq_pkg::OP_INSERT: begin
                        if (stat.full) begin
                            cmd.res_full = 1'b1;
                        end else begin
                            cmd.ins_setup = 1'b1;
                            state_next    = FSM_WALK;
                        end
                    end
                    teq_pkg::OP_CANCEL: begin
                        if (stat.cancel_hit) begin
                            cmd.cancel_ok = 1'b1;
                        end else begin
                            cmd.cancel_miss = 1'b1;
                        end
                    end
                    teq_pkg::OP_RUN: begin
                        if (stat.head_due) begin
                            cmd.fire = 1'b1;
                            if (stat.period_nz) begin
                                state_next = FSM_WALK;
                            end
                        end else begin
                            cmd.not_due = 1'b1;
                        end
                    end
                    teq_pkg::OP_QUERY: begin
                        cmd.query = 1'b1;
                    end
                    default: begin
                        cmd.query = 1'b1;
                    end
                endcase
            end
            FSM_WALK: begin
                if (stat.walk_more) begin
                    cmd.walk_step = 1'b1;
                end else begin
                    cmd.walk_link = 1'b1;
                    state_next    = FSM_FINISH;
                end
            end
            FSM_FINISH: begin
                if (!stat.out_busy) begin
                    cmd.load_out = 1'b1;
                    state_next   = FSM_IDLE;
                end
            end
            default: begin
                state_next = FSM_IDLE;
            end
        endcase
    end

endmodule

[src/teq_dp.sv]
`timescale 1ns / 1ps

module teq_dp (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic [teq_pkg::S_TDATA_BITS-1:0]   s_tdata,
    input  logic [teq_pkg::OP_BITS-1:0]        s_tuser,
    input  logic                               cfg_wr_en,
    input  logic [teq_pkg::IDLE_BITS-1:0]      cfg_wr_data,
    input  teq_pkg::cmd_t                      cmd,
    output teq_pkg::stat_t                     stat,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [teq_pkg::M_TDATA_BITS-1:0]   m_tdata,
    output logic [teq_pkg::STATUS_BITS-1:0]    m_tuser
);

    // captured input word
    teq_pkg::op_t                          op_reg;
    teq_pkg::time_t                        now_reg;
    logic [teq_pkg::DELAY_BITS-1:0]        delay_reg;
    logic [teq_pkg::PERIOD_BITS-1:0]       period_in_reg;
    logic [teq_pkg::TAG_BITS-1:0]          tag_in_reg;
    logic [teq_pkg::HANDLE_BITS-1:0]       handle_reg;

    logic [teq_pkg::IDLE_BITS-1:0]         idle_wait_reg;

    // slot store and order list
    teq_pkg::time_t                        slot_deadline_reg [teq_pkg::QUEUE_DEPTH];
    logic [teq_pkg::PERIOD_BITS-1:0]       slot_period_reg   [teq_pkg::QUEUE_DEPTH];
    logic [teq_pkg::TAG_BITS-1:0]          slot_tag_reg      [teq_pkg::QUEUE_DEPTH];
    logic [teq_pkg::QUEUE_DEPTH-1:0]       slot_valid_reg;
    teq_pkg::slot_t                        order_reg  [teq_pkg::QUEUE_DEPTH];
    teq_pkg::slot_t                        order_next [teq_pkg::QUEUE_DEPTH];
    teq_pkg::slot_t                        order_above [teq_pkg::QUEUE_DEPTH];
    teq_pkg::slot_t                        order_below [teq_pkg::QUEUE_DEPTH];
    teq_pkg::count_t                       count_reg;
    teq_pkg::count_t                       pos_reg;
    teq_pkg::time_t                        new_dl_reg;
    teq_pkg::slot_t                        link_slot_reg;

    // pending result and output register
    teq_pkg::status_t                      res_status_reg;
    logic [teq_pkg::HANDLE_BITS-1:0]       res_handle_reg;
    logic                                  res_fired_reg;
    logic [teq_pkg::TAG_BITS-1:0]          res_tag_reg;
    teq_pkg::time_t                        res_wait_reg;

    logic                                  out_valid_reg;
    teq_pkg::status_t                      out_status_reg;
    logic [teq_pkg::HANDLE_BITS-1:0]       out_handle_reg;
    logic                                  out_fired_reg;
    logic [teq_pkg::TAG_BITS-1:0]          out_tag_reg;
    teq_pkg::time_t                        out_wait_reg;

    teq_pkg::slot_t                        rd_slot;
    teq_pkg::time_t                        rd_dl;
    logic [teq_pkg::PERIOD_BITS-1:0]       rd_per;
    logic [teq_pkg::TAG_BITS-1:0]          rd_tag;
    teq_pkg::slot_t                        free_slot;
    logic                                  free_found;
    teq_pkg::slot_t                        match_pos;
    logic                                  match_found;
    teq_pkg::slot_t                        cancel_slot;
    logic                                  cancel_in_range;
    teq_pkg::count_t                       unlink_pos;
    logic                                  do_unlink;
    logic [teq_pkg::TIME_BITS:0]           diff;
    teq_pkg::time_t                        wait_val;
    teq_pkg::time_t                        ins_dl;
    teq_pkg::time_t                        rel_dl;
    logic                                  relink;

    // single read port: order[pos] then its slot; pos is zero outside the walk
    assign rd_slot = order_reg[pos_reg[teq_pkg::SLOT_BITS-1:0]];
    assign rd_dl   = slot_deadline_reg[rd_slot];
    assign rd_per  = slot_period_reg[rd_slot];
    assign rd_tag  = slot_tag_reg[rd_slot];

    assign cancel_slot     = teq_pkg::SLOT_BITS'(handle_reg);
    assign cancel_in_range = (int'(handle_reg) < teq_pkg::QUEUE_DEPTH);

    always_comb begin
        free_slot   = '0;
        free_found  = 1'b0;
        match_pos   = '0;
        match_found = 1'b0;
        for (int i = teq_pkg::QUEUE_DEPTH - 1; i >= 0; i--) begin
            if (!slot_valid_reg[i]) begin
                free_slot  = teq_pkg::SLOT_BITS'(i);
                free_found = 1'b1;
            end
            if ((teq_pkg::COUNT_BITS'(i) < count_reg) && (order_reg[i] == cancel_slot)) begin
                match_pos   = teq_pkg::SLOT_BITS'(i);
                match_found = 1'b1;
            end
        end
    end

    assign ins_dl = teq_pkg::sat_add(now_reg, delay_reg);
    assign rel_dl = teq_pkg::sat_add(now_reg, rd_per);
    assign relink = cmd.fire && (rd_per != '0);

    assign diff = {1'b0, rd_dl} - {1'b0, now_reg};
    always_comb begin
        if (count_reg == '0) begin
            wait_val = teq_pkg::TIME_BITS'(idle_wait_reg);
        end else if (diff[teq_pkg::TIME_BITS]) begin
            wait_val = '0;
        end else begin
            wait_val = diff[teq_pkg::TIME_BITS-1:0];
        end
    end

    always_comb begin
        stat.op         = op_reg;
        stat.full       = (count_reg == teq_pkg::COUNT_BITS'(teq_pkg::QUEUE_DEPTH))
                          || !free_found;
        stat.cancel_hit = cancel_in_range && slot_valid_reg[cancel_slot] && match_found;
        stat.head_due   = (count_reg != '0) && (rd_dl <= now_reg);
        stat.period_nz  = (rd_per != '0);
        stat.walk_more  = (pos_reg < count_reg) && (rd_dl <= new_dl_reg);
        stat.out_busy   = out_valid_reg && !m_tready;
    end

    // order list: shift toward head on unlink, away from it on link
    assign do_unlink  = cmd.cancel_ok || cmd.fire;
    assign unlink_pos = cmd.cancel_ok ? teq_pkg::COUNT_BITS'(match_pos) : '0;

    for (genvar g = 0; g < teq_pkg::QUEUE_DEPTH; g++) begin : g_ord
        if (g < teq_pkg::QUEUE_DEPTH - 1) begin : g_up
            assign order_above[g] = order_reg[g+1];
        end else begin : g_top
            assign order_above[g] = order_reg[g];
        end
        if (g > 0) begin : g_dn
            assign order_below[g] = order_reg[g-1];
        end else begin : g_bot
            assign order_below[g] = order_reg[g];
        end
    end

    always_comb begin
        for (int i = 0; i < teq_pkg::QUEUE_DEPTH; i++) begin
            order_next[i] = order_reg[i];
            if (do_unlink && (teq_pkg::COUNT_BITS'(i) >= unlink_pos)) begin
                order_next[i] = order_above[i];
            end else if (cmd.walk_link && (teq_pkg::COUNT_BITS'(i) > pos_reg)) begin
                order_next[i] = order_below[i];
            end else if (cmd.walk_link && (teq_pkg::COUNT_BITS'(i) == pos_reg)) begin
                order_next[i] = link_slot_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        for (int i = 0; i < teq_pkg::QUEUE_DEPTH; i++) begin
            order_reg[i] <= order_next[i];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            op_reg        <= teq_pkg::op_t'(s_tuser);
            now_reg       <= s_tdata[teq_pkg::S_NOW_LSB +: teq_pkg::TIME_BITS];
            delay_reg     <= s_tdata[teq_pkg::S_DELAY_LSB +: teq_pkg::DELAY_BITS];
            period_in_reg <= s_tdata[teq_pkg::S_PERIOD_LSB +: teq_pkg::PERIOD_BITS];
            tag_in_reg    <= s_tdata[teq_pkg::S_TAG_LSB +: teq_pkg::TAG_BITS];
            handle_reg    <= s_tdata[teq_pkg::S_HANDLE_LSB +: teq_pkg::HANDLE_BITS];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idle_wait_reg <= teq_pkg::IDLE_WAIT_RESET;
        end else if (cfg_wr_en) begin
            idle_wait_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.ins_setup) begin
            slot_deadline_reg[free_slot] <= ins_dl;
            slot_period_reg[free_slot]   <= period_in_reg;
            slot_tag_reg[free_slot]      <= tag_in_reg;
            new_dl_reg                   <= ins_dl;
            link_slot_reg                <= free_slot;
        end else if (relink) begin
            slot_deadline_reg[rd_slot] <= rel_dl;
            new_dl_reg                 <= rel_dl;
            link_slot_reg              <= rd_slot;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            slot_valid_reg <= '0;
            count_reg      <= '0;
            pos_reg        <= '0;
        end else begin
            if (cmd.ins_setup) begin
                slot_valid_reg[free_slot] <= 1'b1;
            end else if (cmd.cancel_ok) begin
                slot_valid_reg[cancel_slot] <= 1'b0;
            end else if (cmd.fire && !relink) begin
                slot_valid_reg[rd_slot] <= 1'b0;
            end
            if (do_unlink) begin
                count_reg <= count_reg - teq_pkg::count_t'(1);
            end else if (cmd.walk_link) begin
                count_reg <= count_reg + teq_pkg::count_t'(1);
            end
            if (cmd.walk_step) begin
                pos_reg <= pos_reg + teq_pkg::count_t'(1);
            end else if (cmd.walk_link) begin
                pos_reg <= '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.res_full || cmd.ins_setup || cmd.cancel_ok || cmd.cancel_miss
            || cmd.not_due || cmd.fire || cmd.query) begin
            res_status_reg <= teq_pkg::ST_OK;
            res_handle_reg <= '0;
            res_fired_reg  <= 1'b0;
            res_tag_reg    <= '0;
            res_wait_reg   <= '0;
            if (cmd.res_full) begin
                res_status_reg <= teq_pkg::ST_FULL;
            end
            if (cmd.cancel_miss) begin
                res_status_reg <= teq_pkg::ST_NOT_QUEUED;
            end
            if (cmd.not_due) begin
                res_status_reg <= teq_pkg::ST_NOT_DUE;
            end
            if (cmd.ins_setup) begin
                res_handle_reg <= teq_pkg::HANDLE_BITS'(free_slot);
            end
            if (cmd.fire) begin
                res_fired_reg <= 1'b1;
                res_tag_reg   <= rd_tag;
            end
            if (cmd.query) begin
                res_wait_reg <= wait_val;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.load_out) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            out_status_reg <= res_status_reg;
            out_handle_reg <= res_handle_reg;
            out_fired_reg  <= res_fired_reg;
            out_tag_reg    <= res_tag_reg;
            out_wait_reg   <= res_wait_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_status_reg;
    assign m_tdata  = teq_pkg::M_TDATA_BITS'({out_wait_reg, out_tag_reg,
                                              out_fired_reg, out_handle_reg});

endmodule

[src/teq_checker.sv]
`timescale 1ns / 1ps

module teq_monitor (
    input logic                              aclk,
    input logic                              aresetn,
    input logic                              m_axis_tvalid,
    input logic                              m_axis_tready,
    input logic [teq_pkg::M_TDATA_BITS-1:0]  m_axis_tdata,
    input logic [teq_pkg::STATUS_BITS-1:0]   m_axis_tuser
);

    logic                            fired;
    logic [teq_pkg::HANDLE_BITS-1:0] new_handle;
    logic [teq_pkg::TAG_BITS-1:0]    fired_tag;
    teq_pkg::time_t                  wait_ms;

    assign new_handle = m_axis_tdata[teq_pkg::M_HANDLE_LSB +: teq_pkg::HANDLE_BITS];
    assign fired      = m_axis_tdata[teq_pkg::M_FIRED_LSB];
    assign fired_tag  = m_axis_tdata[teq_pkg::M_TAG_LSB +: teq_pkg::TAG_BITS];
    assign wait_ms    = m_axis_tdata[teq_pkg::M_WAIT_LSB +: teq_pkg::TIME_BITS];

    a_reset_clears_out: assert property (@(posedge aclk)
        !aresetn |=> !m_axis_tvalid)
        else $error("result valid after reset");

    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("stalled result changed");

    a_fired_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && fired |-> m_axis_tuser == teq_pkg::ST_OK && wait_ms == '0
            && new_handle == '0)
        else $error("fired result with bad fields");

    a_full_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && m_axis_tuser == teq_pkg::ST_FULL |->
            new_handle == '0 && !fired && wait_ms == '0)
        else $error("full result carries data");

    a_not_due_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && (m_axis_tuser == teq_pkg::ST_NOT_DUE
            || m_axis_tuser == teq_pkg::ST_NOT_QUEUED) |-> !fired && fired_tag == '0)
        else $error("refused request reports a firing");

endmodule

bind timed_event_queue teq_monitor u_teq_monitor (.*);

[tb/teq_checker.sv]
`timescale 1ns / 1ps

module teq_checker
    import teq_pkg::*;
(
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_axis_tvalid,
    input  logic                    s_axis_tready,
    // now_ms, delay_ms, period_ms, event_tag, cancel_handle, zero pad
    input  logic [S_TDATA_BITS-1:0] s_axis_tdata,
    // operation
    input  logic [OP_BITS-1:0]      s_axis_tuser,
    input  logic                    m_axis_tvalid,
    input  logic                    m_axis_tready,
    // new_handle, fired, fired_tag, wait_ms, zero pad
    input  logic [M_TDATA_BITS-1:0] m_axis_tdata,
    // status
    input  logic [STATUS_BITS-1:0]  m_axis_tuser,
    input  logic                    cfg_wr_en,
    input  logic [IDLE_BITS-1:0]    cfg_wr_data,
    output int                      fail_count,
    output int                      pending
);

    typedef struct packed {
        status_t                status;
        logic [HANDLE_BITS-1:0] handle;
        logic                   fired;
        logic [TAG_BITS-1:0]    tag;
        time_t                  wait_ms;
    } outcome_t;

    time_t                  deadline [QUEUE_DEPTH];
    logic [PERIOD_BITS-1:0] reload   [QUEUE_DEPTH];
    logic [TAG_BITS-1:0]    tag_of   [QUEUE_DEPTH];
    logic                   busy     [QUEUE_DEPTH];
    int                     order    [QUEUE_DEPTH];
    int                     queued;
    logic [IDLE_BITS-1:0]   idle_wait;
    outcome_t               pending_outcomes [$];

    function automatic time_t later_by(time_t t, logic [31:0] d);
        logic [TIME_BITS:0] sum;
        sum = {1'b0, t} + (TIME_BITS + 1)'(d);
        if (sum[TIME_BITS]) begin
            return '1;
        end
        return sum[TIME_BITS-1:0];
    endfunction

    // behind every deadline that is not later, so ties keep arrival order
    function automatic void enqueue_slot(int s);
        int pos;
        int i;
        pos = 0;
        while (pos < queued && deadline[order[pos]] <= deadline[s]) begin
            pos++;
        end
        for (i = queued; i > pos; i--) begin
            order[i] = order[i-1];
        end
        order[pos] = s;
        queued++;
    endfunction

    function automatic void dequeue_at(int pos);
        int i;
        for (i = pos; i + 1 < queued; i++) begin
            order[i] = order[i+1];
        end
        queued--;
    endfunction

    function automatic outcome_t timer_outcome(op_t op, time_t now, logic [31:0] delay,
                                               logic [31:0] period, logic [15:0] tag,
                                               logic [3:0] handle);
        outcome_t r;
        int       s;
        int       i;
        r = '0;
        r.status = ST_OK;
        case (op)
            OP_INSERT: begin
                s = 0;
                while (s < QUEUE_DEPTH && busy[s]) begin
                    s++;
                end
                if (queued >= QUEUE_DEPTH || s >= QUEUE_DEPTH) begin
                    r.status = ST_FULL;
                end else begin
                    busy[s]     = 1'b1;
                    deadline[s] = later_by(now, delay);
                    reload[s]   = period;
                    tag_of[s]   = tag;
                    enqueue_slot(s);
                    r.handle = s[HANDLE_BITS-1:0];
                end
            end
            OP_CANCEL: begin
                r.status = ST_NOT_QUEUED;
                if (busy[handle]) begin
                    for (i = 0; i < queued; i++) begin
                        if (order[i] == int'(handle)) begin
                            dequeue_at(i);
                            busy[handle] = 1'b0;
                            r.status = ST_OK;
                            break;
                        end
                    end
                end
            end
            OP_RUN: begin
                if (queued == 0 || deadline[order[0]] > now) begin
                    r.status = ST_NOT_DUE;
                end else begin
                    s = order[0];
                    dequeue_at(0);
                    r.fired = 1'b1;
                    r.tag   = tag_of[s];
                    if (reload[s] != 0) begin
                        deadline[s] = later_by(now, reload[s]);
                        enqueue_slot(s);
                    end else begin
                        busy[s] = 1'b0;
                    end
                end
            end
            default: begin
                if (queued == 0) begin
                    r.wait_ms = time_t'(idle_wait);
                end else if (deadline[order[0]] > now) begin
                    r.wait_ms = deadline[order[0]] - now;
                end
            end
        endcase
        return r;
    endfunction

    function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
        if (want !== got) begin
            $error("%s expected %0h actual %0h", name, want, got);
            fail_count++;
        end
    endfunction

    always @(posedge aclk) begin
        outcome_t want;
        if (!aresetn) begin
            foreach (busy[k]) begin
                busy[k] = 1'b0;
            end
            queued     = 0;
            idle_wait  = IDLE_WAIT_RESET;
            fail_count = 0;
            pending_outcomes.delete();
        end else begin
            if (cfg_wr_en) begin
                idle_wait = cfg_wr_data;
            end
            if (m_axis_tvalid && m_axis_tready) begin
                if (pending_outcomes.size() == 0) begin
                    $error("result word with no outstanding expectation");
                    fail_count++;
                end else begin
                    want = pending_outcomes.pop_front();
                    check_field("status", want.status, m_axis_tuser);
                    check_field("new_handle", want.handle,
                                m_axis_tdata[M_HANDLE_LSB +: HANDLE_BITS]);
                    check_field("fired", want.fired, m_axis_tdata[M_FIRED_LSB]);
                    check_field("fired_tag", want.tag, m_axis_tdata[M_TAG_LSB +: TAG_BITS]);
                    check_field("wait_ms", want.wait_ms,
                                m_axis_tdata[M_WAIT_LSB +: TIME_BITS]);
                end
            end
            if (s_axis_tvalid && s_axis_tready) begin
                pending_outcomes.push_back(timer_outcome(
                    op_t'(s_axis_tuser),
                    s_axis_tdata[S_NOW_LSB +: TIME_BITS],
                    s_axis_tdata[S_DELAY_LSB +: DELAY_BITS],
                    s_axis_tdata[S_PERIOD_LSB +: PERIOD_BITS],
                    s_axis_tdata[S_TAG_LSB +: TAG_BITS],
                    s_axis_tdata[S_HANDLE_LSB +: HANDLE_BITS]));
            end
        end
        pending = pending_outcomes.size();
    end

endmodule

[tb/testbench.sv]
`timescale 1ns / 1ps

module testbench;
    import teq_pkg::*;

    localparam int HALF_PERIOD    = 10;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int DRAIN_CYCLES   = 30;
    localparam int HOLD_CYCLES    = 400;

    typedef enum int {
        STYLE_FILL,
        STYLE_DRAIN,
        STYLE_SWEEP,
        STYLE_MIXED,
        STYLE_NOISE
    } style_t;

    logic                    aclk          = 1'b0;
    logic                    aresetn       = 1'b0;
    logic                    s_axis_tvalid = 1'b0;
    logic                    s_axis_tready;
    logic [S_TDATA_BITS-1:0] s_axis_tdata  = '0;
    logic [OP_BITS-1:0]      s_axis_tuser  = '0;
    logic                    m_axis_tvalid;
    logic                    m_axis_tready = 1'b0;
    logic [M_TDATA_BITS-1:0] m_axis_tdata;
    logic [STATUS_BITS-1:0]  m_axis_tuser;
    logic                    cfg_wr_en     = 1'b0;
    logic [IDLE_BITS-1:0]    cfg_wr_data   = '0;

    int    fail_count;
    int    pending;
    int    tx_idle_pct = 16;
    int    rx_idle_pct = 73;
    int    hold_reqs   = 0;
    int    hold_seen   = 0;
    int    hold_left   = 0;
    int    idle_cycles = 0;
    time_t cur_now     = '0;

    always #HALF_PERIOD aclk = ~aclk;

    timed_event_queue u_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data)
    );

    teq_checker u_checker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .fail_count    (fail_count),
        .pending       (pending)
    );

    // receiver, with one long hold-off in the last random phase
    always @(negedge aclk) begin
        if (hold_seen != hold_reqs) begin
            hold_seen = hold_reqs;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // returns at the accepting rising edge
    task automatic send_word(op_t op, time_t now, logic [31:0] delay, logic [31:0] period,
                             logic [15:0] tag, logic [3:0] handle);
        logic [S_TDATA_BITS-1:0] word;
        word = '0;
        word[S_NOW_LSB +: TIME_BITS]      = now;
        word[S_DELAY_LSB +: DELAY_BITS]   = delay;
        word[S_PERIOD_LSB +: PERIOD_BITS] = period;
        word[S_TAG_LSB +: TAG_BITS]       = tag;
        word[S_HANDLE_LSB +: HANDLE_BITS] = handle;
        @(negedge aclk);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= word;
        s_axis_tuser  <= op;
        do @(posedge aclk); while (!s_axis_tready);
    endtask

    task automatic random_word(style_t style);
        op_t         op;
        time_t       now;
        logic [31:0] delay;
        logic [31:0] period;
        int          pick;
        cur_now += $urandom_range(0, 8);
        now    = cur_now;
        delay  = ($urandom_range(0, 19) == 0) ? $urandom() : $urandom_range(0, 100);
        period = $urandom_range(0, 1) ? 32'd0 : $urandom_range(1, 120);
        pick   = $urandom_range(0, 99);
        case (style)
            STYLE_FILL:  op = (pick < 85) ? OP_INSERT : OP_QUERY;
            STYLE_DRAIN: op = (pick < 80) ? OP_RUN : OP_QUERY;
            STYLE_SWEEP: op = OP_CANCEL;
            STYLE_MIXED: begin
                if (pick < 35) begin
                    op = OP_INSERT;
                end else if (pick < 50) begin
                    op = OP_CANCEL;
                end else if (pick < 80) begin
                    op = OP_RUN;
                end else begin
                    op = OP_QUERY;
                end
            end
            default: begin
                op     = op_t'($urandom_range(0, 3));
                now    = time_t'({$urandom(), $urandom()});
                delay  = $urandom();
                period = $urandom();
            end
        endcase
        send_word(op, now, delay, period, 16'($urandom_range(0, 65535)),
                  4'($urandom_range(0, 15)));
    endtask

    task automatic run_random(int count);
        int     done;
        int     kind;
        int     len;
        int     k;
        style_t style;
        done = 0;
        while (done < count) begin
            kind = $urandom_range(0, 19);
            if (kind == 19) begin
                cur_now = {TIME_BITS{1'b1}} - time_t'($urandom_range(0, 400));
            end else if (kind == 18) begin
                cur_now = time_t'({$urandom(), $urandom()});
            end
            if (kind < 5) begin
                style = STYLE_FILL;
                len   = $urandom_range(4, 18);
            end else if (kind < 10) begin
                style = STYLE_DRAIN;
                len   = $urandom_range(4, 16);
                cur_now += $urandom_range(0, 200);
            end else if (kind < 12) begin
                style = STYLE_SWEEP;
                len   = QUEUE_DEPTH;
            end else if (kind < 14) begin
                style = STYLE_NOISE;
                len   = $urandom_range(1, 4);
            end else begin
                style = STYLE_MIXED;
                len   = $urandom_range(8, 20);
            end
            for (k = 0; k < len; k++) begin
                random_word(style);
            end
            done += len;
        end
    endtask

    task automatic settle(int extra);
        @(negedge aclk);
        s_axis_tvalid <= 1'b0;
        while (pending != 0) begin
            @(negedge aclk);
        end
        repeat (extra) @(negedge aclk);
    endtask

    task automatic write_idle_wait(logic [IDLE_BITS-1:0] value);
        settle(DRAIN_CYCLES);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(negedge aclk);
        cfg_wr_en   <= 1'b0;
    endtask

    initial begin
        int i;
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // empty queue cases
        send_word(OP_QUERY, 48'd0, 0, 0, 0, 0);
        send_word(OP_RUN, 48'd0, 0, 0, 0, 0);
        send_word(OP_CANCEL, 48'd0, 0, 0, 0, 4'd0);
        // equal deadlines keep arrival order, earlier one goes ahead
        send_word(OP_INSERT, 48'd100, 32'd50, 32'd0, 16'hFFFF, 0);
        send_word(OP_INSERT, 48'd100, 32'd50, 32'd30, 16'h0001, 0);
        send_word(OP_INSERT, 48'd100, 32'd10, 32'd0, 16'h0000, 0);
        send_word(OP_QUERY, 48'd100, 0, 0, 0, 0);
        send_word(OP_QUERY, 48'd200, 0, 0, 0, 0);
        send_word(OP_RUN, 48'd105, 0, 0, 0, 0);
        send_word(OP_RUN, 48'd150, 0, 0, 0, 0);
        send_word(OP_RUN, 48'd150, 0, 0, 0, 0);
        send_word(OP_RUN, 48'd150, 0, 0, 0, 0);
        send_word(OP_CANCEL, 48'd150, 0, 0, 0, 4'd1);
        // saturated deadline, then saturated reload
        send_word(OP_INSERT, '1, '1, '1, 16'hA5A5, 4'hF);
        send_word(OP_RUN, '1, 0, 0, 0, 0);
        send_word(OP_QUERY, 48'd0, 0, 0, 0, 0);
        // fill up, last insert hits a full queue
        for (i = 0; i < QUEUE_DEPTH; i++) begin
            send_word(OP_INSERT, 48'd0, i * 7, i[0] ? 32'd5 : 32'd0,
                      16'($urandom_range(0, 65535)), 0);
        end
        send_word(OP_CANCEL, 48'd0, 0, 0, 0, 4'd15);

        write_idle_wait(16'd0);
        run_random(500);

        write_idle_wait(16'hFFFF);
        tx_idle_pct = 73;
        rx_idle_pct <= 16;
        run_random(500);

        write_idle_wait(16'($urandom_range(1, 65534)));
        tx_idle_pct = 0;
        rx_idle_pct <= 0;
        hold_reqs   <= hold_reqs + 1;
        run_random(500);

        settle(DRAIN_CYCLES);
        if (fail_count == 0 && pending == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
